### hdl/tode_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tode_pkg
// Shared types, constants and fixed-point helpers for the 2x2 trapezoidal
// ODE step pipeline.
// ----------------------------------------------------------------------------
package tode_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DIV_STEPS     = 32;

    localparam logic signed [63:0] MID_MAX = 64'sd2147483647;
    localparam logic signed [63:0] MID_MIN = -64'sd2147483647;

    localparam logic signed [31:0] OUT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] OUT_MIN = 32'sh8000_0000;

    localparam logic [32:0] QPOS_LIMIT = 33'h0_7FFF_FFFF;
    localparam logic [32:0] QNEG_LIMIT = 33'h0_8000_0000;

    typedef struct packed {
        logic signed [31:0] c00;
        logic signed [31:0] c01;
        logic signed [31:0] c10;
        logic signed [31:0] c11;
        logic signed [31:0] x0;
        logic signed [31:0] x1;
    } mid_t;

    typedef struct packed {
        logic signed [63:0] det;
        logic signed [63:0] n0;
        logic signed [63:0] n1;
    } prod_t;

    function automatic logic signed [63:0] mul_ss(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        mul_ss = a * b;
    endfunction

    // divide by 2^s, round to nearest, ties away from zero
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int s);
        logic signed [63:0] half;
        logic signed [63:0] bias;
        half = 64'sd1 <<< (s - 1);
        bias = $signed({63'd0, v[63]});
        rnd_shift = (v + half - bias) >>> s;
    endfunction

    function automatic logic signed [31:0] sat_mid(input logic signed [63:0] v);
        if (v > MID_MAX) begin
            sat_mid = MID_MAX[31:0];
        end
        else if (v < MID_MIN) begin
            sat_mid = MID_MIN[31:0];
        end
        else begin
            sat_mid = v[31:0];
        end
    endfunction

endpackage
`default_nettype wire

### hdl/trapezoid_ode_step_2x2.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trapezoid_ode_step_2x2
// One trapezoidal-rule step of y' = B y for a 2x2 system, solved by
// Cramer's rule in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while stall is low and returns exactly one
// result per item, in order. The front end forms C and x, the cross stage
// forms the determinant and numerators, the divider conditions the operands,
// runs its 32 quotient stages (one bit each) and rounds, and the output
// register follows. A skid register behind the output holds one result, so
// stall is driven from a register. Results saturate to Q16.16; a zero
// determinant sets singular and returns zeros.
// ----------------------------------------------------------------------------
module trapezoid_ode_step_2x2 #(
    parameter int FRAC_BITS = tode_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               valid,
    output logic                    stall,
    input  wire logic signed [31:0] b_top_left,
    input  wire logic signed [31:0] b_top_right,
    input  wire logic signed [31:0] b_bottom_left,
    input  wire logic signed [31:0] b_bottom_right,
    input  wire logic signed [31:0] start_first,
    input  wire logic signed [31:0] start_second,
    input  wire logic        [30:0] final_time,

    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic signed [31:0]      end_first,
    output logic signed [31:0]      end_second,
    output logic                    singular
);

    logic               adv;
    logic               mid_valid;
    tode_pkg::mid_t     mid;
    logic               prod_valid;
    tode_pkg::prod_t    prod;
    logic               res_valid;
    logic signed [31:0] res_first;
    logic signed [31:0] res_second;
    logic               res_singular;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [31:0] out_first_reg;
    logic signed [31:0] out_first_next;
    logic signed [31:0] out_second_reg;
    logic signed [31:0] out_second_next;
    logic               out_sing_reg;
    logic               out_sing_next;

    logic               skid_valid_reg;
    logic               skid_valid_next;
    logic signed [31:0] skid_first_reg;
    logic signed [31:0] skid_first_next;
    logic signed [31:0] skid_second_reg;
    logic signed [31:0] skid_second_next;
    logic               skid_sing_reg;
    logic               skid_sing_next;

    assign adv   = !skid_valid_reg;
    assign stall = skid_valid_reg;

    tode_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (adv),
        .load           (valid),
        .b_top_left     (b_top_left),
        .b_top_right    (b_top_right),
        .b_bottom_left  (b_bottom_left),
        .b_bottom_right (b_bottom_right),
        .start_first    (start_first),
        .start_second   (start_second),
        .final_time     (final_time),
        .mid_valid      (mid_valid),
        .mid            (mid)
    );

    tode_cross u_cross (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .mid_valid  (mid_valid),
        .mid        (mid),
        .prod_valid (prod_valid),
        .prod       (prod)
    );

    tode_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (adv),
        .prod_valid   (prod_valid),
        .prod         (prod),
        .res_valid    (res_valid),
        .res_first    (res_first),
        .res_second   (res_second),
        .res_singular (res_singular)
    );

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_first_next   = out_first_reg;
        out_second_next  = out_second_reg;
        out_sing_next    = out_sing_reg;
        skid_valid_next  = skid_valid_reg;
        skid_first_next  = skid_first_reg;
        skid_second_next = skid_second_reg;
        skid_sing_next   = skid_sing_reg;

        if (skid_valid_reg)
        begin
            // drain the skid once the held result transfers
            if (!result_stall)
            begin
                out_valid_next  = 1'b1;
                out_first_next  = skid_first_reg;
                out_second_next = skid_second_reg;
                out_sing_next   = skid_sing_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || !result_stall)
        begin
            out_valid_next  = res_valid;
            out_first_next  = res_first;
            out_second_next = res_second;
            out_sing_next   = res_singular;
        end
        else if (res_valid)
        begin
            skid_valid_next  = 1'b1;
            skid_first_next  = res_first;
            skid_second_next = res_second;
            skid_sing_next   = res_singular;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_first_reg   <= out_first_next;
        out_second_reg  <= out_second_next;
        out_sing_reg    <= out_sing_next;
        skid_first_reg  <= skid_first_next;
        skid_second_reg <= skid_second_next;
        skid_sing_reg   <= skid_sing_next;
    end

    assign result_valid = out_valid_reg;
    assign end_first    = out_first_reg;
    assign end_second   = out_second_reg;
    assign singular     = out_sing_reg;

    a_skid_behind_out : assert property (
        @(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg
    ) else $error("skid holds a result while the output register is empty");

    a_skid_fill_on_stall : assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && result_stall && res_valid)
    ) else $error("skid filled without a stalled output");

    a_singular_zero : assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_sing_reg) |-> (end_first == '0 && end_second == '0)
    ) else $error("singular result carries nonzero components");

    a_frozen_no_result : assert property (
        @(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && result_stall) |=> (skid_valid_reg && $stable(skid_first_reg))
    ) else $error("skid contents lost while output stalled");

endmodule
`default_nettype wire

### hdl/tode_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tode_front
// Four-stage front end: forms C = I - B t/2 and x = (I + B t/2) y0.
// ----------------------------------------------------------------------------
module tode_front #(
    parameter int FRAC_BITS = tode_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               load,
    input  wire logic signed [31:0] b_top_left,
    input  wire logic signed [31:0] b_top_right,
    input  wire logic signed [31:0] b_bottom_left,
    input  wire logic signed [31:0] b_bottom_right,
    input  wire logic signed [31:0] start_first,
    input  wire logic signed [31:0] start_second,
    input  wire logic        [30:0] final_time,
    output logic                    mid_valid,
    output tode_pkg::mid_t          mid
);

    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    logic signed [31:0] t_s;

    logic [3:0] v_reg;
    logic [3:0] v_next;

    logic signed [63:0] pbt_reg [4];
    logic signed [63:0] pbt_next [4];
    logic signed [63:0] pby_reg [4];
    logic signed [63:0] pby_next [4];
    logic signed [31:0] y1_reg [2];
    logic signed [31:0] t1_reg;

    logic signed [31:0] c2_reg [4];
    logic signed [31:0] c2_next [4];
    logic signed [31:0] s2_reg [2];
    logic signed [31:0] s2_next [2];
    logic signed [31:0] y2_reg [2];
    logic signed [31:0] t2_reg;

    logic signed [63:0] pst_reg [2];
    logic signed [63:0] pst_next [2];
    logic signed [31:0] c3_reg [4];
    logic signed [31:0] y3_reg [2];

    tode_pkg::mid_t mid_reg;
    tode_pkg::mid_t mid_next;

    assign t_s = $signed({1'b0, final_time});

    always_comb
    begin
        v_next = {v_reg[2:0], load};

        pbt_next[0] = tode_pkg::mul_ss(b_top_left, t_s);
        pbt_next[1] = tode_pkg::mul_ss(b_top_right, t_s);
        pbt_next[2] = tode_pkg::mul_ss(b_bottom_left, t_s);
        pbt_next[3] = tode_pkg::mul_ss(b_bottom_right, t_s);
        pby_next[0] = tode_pkg::mul_ss(b_top_left, start_first);
        pby_next[1] = tode_pkg::mul_ss(b_top_right, start_second);
        pby_next[2] = tode_pkg::mul_ss(b_bottom_left, start_first);
        pby_next[3] = tode_pkg::mul_ss(b_bottom_right, start_second);

        c2_next[0] = tode_pkg::sat_mid(ONE - tode_pkg::rnd_shift(pbt_reg[0], FRAC_BITS + 1));
        c2_next[1] = tode_pkg::sat_mid(64'sd0 - tode_pkg::rnd_shift(pbt_reg[1], FRAC_BITS + 1));
        c2_next[2] = tode_pkg::sat_mid(64'sd0 - tode_pkg::rnd_shift(pbt_reg[2], FRAC_BITS + 1));
        c2_next[3] = tode_pkg::sat_mid(ONE - tode_pkg::rnd_shift(pbt_reg[3], FRAC_BITS + 1));
        s2_next[0] = tode_pkg::sat_mid(tode_pkg::rnd_shift(pby_reg[0], FRAC_BITS)
                                     + tode_pkg::rnd_shift(pby_reg[1], FRAC_BITS));
        s2_next[1] = tode_pkg::sat_mid(tode_pkg::rnd_shift(pby_reg[2], FRAC_BITS)
                                     + tode_pkg::rnd_shift(pby_reg[3], FRAC_BITS));

        pst_next[0] = tode_pkg::mul_ss(s2_reg[0], t2_reg);
        pst_next[1] = tode_pkg::mul_ss(s2_reg[1], t2_reg);

        mid_next.c00 = c3_reg[0];
        mid_next.c01 = c3_reg[1];
        mid_next.c10 = c3_reg[2];
        mid_next.c11 = c3_reg[3];
        mid_next.x0  = tode_pkg::sat_mid(64'(y3_reg[0])
                                       + tode_pkg::rnd_shift(pst_reg[0], FRAC_BITS + 1));
        mid_next.x1  = tode_pkg::sat_mid(64'(y3_reg[1])
                                       + tode_pkg::rnd_shift(pst_reg[1], FRAC_BITS + 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pbt_reg <= pbt_next;
            pby_reg <= pby_next;
            y1_reg[0] <= start_first;
            y1_reg[1] <= start_second;
            t1_reg <= t_s;

            c2_reg <= c2_next;
            s2_reg <= s2_next;
            y2_reg <= y1_reg;
            t2_reg <= t1_reg;

            pst_reg <= pst_next;
            c3_reg <= c2_reg;
            y3_reg <= y2_reg;

            mid_reg <= mid_next;
        end
    end

    assign mid_valid = v_reg[3];
    assign mid       = mid_reg;

endmodule
`default_nettype wire

### hdl/tode_cross.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tode_cross
// Two-stage cross products: det C and the two Cramer numerators.
// ----------------------------------------------------------------------------
module tode_cross (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            mid_valid,
    input  wire tode_pkg::mid_t  mid,
    output logic                 prod_valid,
    output tode_pkg::prod_t      prod
);

    logic [1:0] v_reg;
    logic [1:0] v_next;

    logic signed [63:0] p_reg [6];
    logic signed [63:0] p_next [6];

    tode_pkg::prod_t prod_reg;
    tode_pkg::prod_t prod_next;

    always_comb
    begin
        v_next = {v_reg[0], mid_valid};

        p_next[0] = tode_pkg::mul_ss(mid.c00, mid.c11);
        p_next[1] = tode_pkg::mul_ss(mid.c01, mid.c10);
        p_next[2] = tode_pkg::mul_ss(mid.x0, mid.c11);
        p_next[3] = tode_pkg::mul_ss(mid.c01, mid.x1);
        p_next[4] = tode_pkg::mul_ss(mid.c00, mid.x1);
        p_next[5] = tode_pkg::mul_ss(mid.x0, mid.c10);

        prod_next.det = p_reg[0] - p_reg[1];
        prod_next.n0  = p_reg[2] - p_reg[3];
        prod_next.n1  = p_reg[4] - p_reg[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= p_next;
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = v_reg[1];
    assign prod       = prod_reg;

endmodule
`default_nettype wire

### hdl/tode_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tode_div
// Pipelined restoring divider, two lanes sharing one divisor: one quotient
// bit per stage, then round to nearest and saturate to 32 bits.
// ----------------------------------------------------------------------------
module tode_div #(
    parameter int FRAC_BITS = tode_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               prod_valid,
    input  wire tode_pkg::prod_t    prod,
    output logic                    res_valid,
    output logic signed [31:0]      res_first,
    output logic signed [31:0]      res_second,
    output logic                    res_singular
);

    localparam int STEPS = tode_pkg::DIV_STEPS;
    localparam int NW    = 64 + FRAC_BITS;
    localparam int CW    = (NW > 64 + STEPS) ? NW : 64 + STEPS;

    // operand conditioning
    logic               va_reg;
    logic        [63:0] ua_reg [2];
    logic        [63:0] ua_next [2];
    logic               nega_reg [2];
    logic               nega_next [2];
    logic        [63:0] uda_reg;
    logic        [63:0] uda_next;
    logic               singa_reg;
    logic               singa_next;

    // quotient pipeline
    logic [STEPS:0]     vs_reg;
    logic [STEPS:0]     vs_next;
    logic        [63:0] rem_reg [STEPS+1][2];
    logic        [63:0] rem_next [STEPS+1][2];
    logic        [31:0] low_reg [STEPS+1][2];
    logic        [31:0] low_next [STEPS+1][2];
    logic        [31:0] q_reg [STEPS+1][2];
    logic        [31:0] q_next [STEPS+1][2];
    logic               ovf_reg [STEPS+1][2];
    logic               ovf_next [STEPS+1][2];
    logic               neg_reg [STEPS+1][2];
    logic               neg_next [STEPS+1][2];
    logic        [63:0] ud_reg [STEPS+1];
    logic        [63:0] ud_next [STEPS+1];
    logic [STEPS:0]     sing_reg;
    logic [STEPS:0]     sing_next;

    // result
    logic               vf_reg;
    logic               vf_next;
    logic signed [31:0] end_reg [2];
    logic signed [31:0] end_next [2];
    logic               singf_reg;

    always_comb
    begin
        logic signed [63:0] n_sel;
        logic    [NW-1:0]   nfull;
        logic    [CW-1:0]   num_ext;
        logic    [CW-1:0]   den_ext;
        logic        [63:0] trial;
        logic               ge;
        logic               half;
        logic        [32:0] qr;

        n_sel = prod.n0;
        nfull = '0;
        num_ext = '0;
        den_ext = '0;
        trial = '0;
        ge = 1'b0;
        half = 1'b0;
        qr = '0;

        // take magnitudes and signs
        for (int l = 0; l < 2; l++)
        begin
            n_sel = (l == 0) ? prod.n0 : prod.n1;
            ua_next[l]   = n_sel[63] ? 64'(64'sd0 - n_sel) : 64'(n_sel);
            nega_next[l] = n_sel[63] ^ prod.det[63];
        end
        uda_next   = prod.det[63] ? 64'(64'sd0 - prod.det) : 64'(prod.det);
        singa_next = (prod.det == 64'sd0);

        // range check and initial remainder
        vs_next[0]   = va_reg;
        ud_next[0]   = uda_reg;
        sing_next[0] = singa_reg;
        den_ext = CW'({uda_reg, {STEPS{1'b0}}});
        for (int l = 0; l < 2; l++)
        begin
            nfull = {ua_reg[l], {FRAC_BITS{1'b0}}};
            num_ext = CW'(nfull);
            ovf_next[0][l] = (num_ext >= den_ext);
            neg_next[0][l] = nega_reg[l];
            rem_next[0][l] = 64'(nfull[NW-1:STEPS]);
            low_next[0][l] = nfull[STEPS-1:0];
            q_next[0][l]   = '0;
        end

        // one quotient bit per stage
        for (int k = 0; k < STEPS; k++)
        begin
            vs_next[k+1]   = vs_reg[k];
            ud_next[k+1]   = ud_reg[k];
            sing_next[k+1] = sing_reg[k];
            for (int l = 0; l < 2; l++)
            begin
                trial = {rem_reg[k][l][62:0], low_reg[k][l][31]};
                ge    = (trial >= ud_reg[k]);
                rem_next[k+1][l] = ge ? (trial - ud_reg[k]) : trial;
                q_next[k+1][l]   = {q_reg[k][l][30:0], ge};
                low_next[k+1][l] = {low_reg[k][l][30:0], 1'b0};
                ovf_next[k+1][l] = ovf_reg[k][l];
                neg_next[k+1][l] = neg_reg[k][l];
            end
        end

        // round and saturate
        vf_next = vs_reg[STEPS];
        for (int l = 0; l < 2; l++)
        begin
            half = (rem_reg[STEPS][l] >= (ud_reg[STEPS] - rem_reg[STEPS][l]));
            qr   = {1'b0, q_reg[STEPS][l]} + {32'd0, half};
            if (sing_reg[STEPS])
            begin
                end_next[l] = '0;
            end
            else if (!neg_reg[STEPS][l])
            begin
                if (ovf_reg[STEPS][l] || (qr > tode_pkg::QPOS_LIMIT))
                begin
                    end_next[l] = tode_pkg::OUT_MAX;
                end
                else
                begin
                    end_next[l] = $signed(qr[31:0]);
                end
            end
            else
            begin
                if (ovf_reg[STEPS][l] || (qr > tode_pkg::QNEG_LIMIT))
                begin
                    end_next[l] = tode_pkg::OUT_MIN;
                end
                else
                begin
                    end_next[l] = $signed(32'd0 - qr[31:0]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vs_reg <= '0;
            vf_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= prod_valid;
            vs_reg <= vs_next;
            vf_reg <= vf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg    <= ua_next;
            nega_reg  <= nega_next;
            uda_reg   <= uda_next;
            singa_reg <= singa_next;

            rem_reg  <= rem_next;
            low_reg  <= low_next;
            q_reg    <= q_next;
            ovf_reg  <= ovf_next;
            neg_reg  <= neg_next;
            ud_reg   <= ud_next;
            sing_reg <= sing_next;

            end_reg   <= end_next;
            singf_reg <= sing_reg[STEPS];
        end
    end

    assign res_valid    = vf_reg;
    assign res_first    = end_reg[0];
    assign res_second   = end_reg[1];
    assign res_singular = singf_reg;

endmodule
`default_nettype wire
